[src/aob_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aob_pkg
// Shared widths, register map and types of the straight-alpha over compositor.
// ----------------------------------------------------------------------------
package aob_pkg;

    // pixel and channel widths
    localparam int unsigned PX_W    = 32;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned N_COLOR = 3;
    localparam int unsigned PROD_W  = 16;

    // divider: numerator, denominator and quotient widths
    localparam int unsigned NUM_W     = 26;
    localparam int unsigned DEN_W     = 16;
    localparam int unsigned Q_W       = 9;
    localparam int unsigned DIV_STEPS = 3;
    localparam int unsigned DIV_STGS  = 3;

    localparam logic [CH_W-1:0] CH_MAX   = 8'd255;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd0;
    localparam logic [DEN_W-1:0] A_ROUND = 16'd127;

    // configuration register map
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_BLEND_MODE = 3'd0;

    // blend mode codes
    localparam logic MODE_SOURCE = 1'b0;
    localparam logic MODE_OVER   = 1'b1;

    typedef logic [PX_W-1:0]  t_px;
    typedef logic [NUM_W-1:0] t_num;
    typedef logic [DEN_W-1:0] t_den;
    typedef logic [Q_W-1:0]   t_quo;

endpackage

`default_nettype wire

[src/aob_div_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aob_div_stage
// Three restoring-division steps: produces quotient bits HI down to HI-2.
// ----------------------------------------------------------------------------
module aob_div_stage #(
    parameter int unsigned HI = 8
) (
    input  wire aob_pkg::t_num i_rem,
    input  wire aob_pkg::t_quo i_quo,
    input  wire aob_pkg::t_den i_den,
    output aob_pkg::t_num      o_rem,
    output aob_pkg::t_quo      o_quo
);

    // compare and subtract shifted divisor, one bit per step
    always_comb begin
        aob_pkg::t_num rem;
        aob_pkg::t_quo quo;
        aob_pkg::t_num dsh;
        rem = i_rem;
        quo = i_quo;
        for (int j = 0; j < aob_pkg::DIV_STEPS; j++) begin
            dsh = aob_pkg::t_num'(i_den) << (HI - j);
            if (rem >= dsh) begin
                rem = rem - dsh;
                quo[HI - j] = 1'b1;
            end
        end
        o_rem = rem;
        o_quo = quo;
    end

endmodule

`default_nettype wire

[src/apng_over_blend.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apng_over_blend
// Straight-alpha RGBA8 compositor, source or over blending per pixel.
// ----------------------------------------------------------------------------
// One pixel pair enters per cycle while o_stall is low. The six register
// stages are: alpha products, weighted numerators, three stages of a
// 3-bit-per-stage restoring divider (one divider per color channel in
// each), and an output stage that applies clamps and the transparent,
// opaque and source-mode bypasses. Each stage moves whenever the next is
// empty or moving, so bubbles are squeezed out under output stall.
// blend_mode lives at byte address 0 of the register port.
module apng_over_blend (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input items
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [31:0]                  i_src_pixel,
    input  wire  [31:0]                  i_dst_pixel,
    // result items
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [31:0]                  o_out_pixel,
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [aob_pkg::PADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int unsigned NSTG = 6;
    localparam int unsigned CW   = aob_pkg::CH_W;

    logic r_mode;
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    // register port
    assign pready = 1'b1;
    assign prdata = {31'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= aob_pkg::MODE_SOURCE;
        end else if (psel && penable && pwrite && (paddr == aob_pkg::ADDR_BLEND_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    // stage enables: a stage moves if empty or its successor moves
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: alpha products and bypass decode
    logic [CW-1:0] sa, da, inv;
    logic          n_byp;
    aob_pkg::t_px  n_bpx;

    assign sa  = i_src_pixel[31:24];
    assign da  = i_dst_pixel[31:24];
    assign inv = aob_pkg::CH_MAX - sa;

    always_comb begin
        n_byp = 1'b1;
        n_bpx = i_src_pixel;
        if (r_mode == aob_pkg::MODE_OVER) begin
            if (sa == aob_pkg::CH_ZERO) begin
                n_bpx = i_dst_pixel;
            end else if (sa == aob_pkg::CH_MAX) begin
                n_bpx = i_src_pixel;
            end else begin
                n_byp = 1'b0;
            end
        end
    end

    logic [aob_pkg::PROD_W-1:0] r_ssa [aob_pkg::N_COLOR];
    logic [aob_pkg::PROD_W-1:0] r_dda [aob_pkg::N_COLOR];
    logic [CW-1:0]              r_inv;
    aob_pkg::t_den              r_a0;
    logic                       r_byp0;
    aob_pkg::t_px               r_bpx0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int c = 0; c < aob_pkg::N_COLOR; c++) begin
                r_ssa[c] <= {8'd0, i_src_pixel[c*CW +: CW]} * {8'd0, sa};
                r_dda[c] <= {8'd0, i_dst_pixel[c*CW +: CW]} * {8'd0, da};
            end
            r_inv  <= inv;
            r_a0   <= aob_pkg::t_den'({sa, 8'd0} - {8'd0, sa})
                    + aob_pkg::t_den'({8'd0, da} * {8'd0, inv});
            r_byp0 <= n_byp;
            r_bpx0 <= n_bpx;
        end
    end

    // stage 1: rounded numerators and alpha quotient
    // index 0 of these arrays is stage 1 (r_quo has none), later indexes the divider stages
    aob_pkg::t_num  r_rem [aob_pkg::DIV_STGS+1][aob_pkg::N_COLOR];
    aob_pkg::t_quo  r_quo [1:aob_pkg::DIV_STGS][aob_pkg::N_COLOR];
    aob_pkg::t_den  r_den [aob_pkg::DIV_STGS+1];
    logic [CW-1:0]  r_al  [aob_pkg::DIV_STGS+1];
    logic           r_byp [aob_pkg::DIV_STGS+1];
    aob_pkg::t_px   r_bpx [aob_pkg::DIV_STGS+1];

    logic [16:0] ax;
    logic [16:0] aq;
    assign ax = {1'b0, r_a0} + {1'b0, aob_pkg::A_ROUND};
    // x / 255 as (x + (x >> 8) + 1) >> 8, exact over this range
    assign aq = (ax + (ax >> 8) + 17'd1) >> 8;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int c = 0; c < aob_pkg::N_COLOR; c++) begin
                r_rem[0][c] <= aob_pkg::t_num'((32'(r_ssa[c]) << 8) - 32'(r_ssa[c]))
                             + aob_pkg::t_num'(r_dda[c]) * aob_pkg::t_num'(r_inv)
                             + aob_pkg::t_num'(r_a0 >> 1);
            end
            r_den[0] <= r_a0;
            r_al[0]  <= (aq > 17'(aob_pkg::CH_MAX)) ? aob_pkg::CH_MAX : aq[CW-1:0];
            r_byp[0] <= r_byp0 || (r_a0 == '0);
            r_bpx[0] <= r_byp0 ? r_bpx0 : '0;
        end
    end

    // stages 2..4: restoring divider, three quotient bits per stage
    for (genvar g = 0; g < aob_pkg::DIV_STGS; g++) begin : g_div
        for (genvar c = 0; c < aob_pkg::N_COLOR; c++) begin : g_ch
            aob_pkg::t_num rem_n;
            aob_pkg::t_quo quo_n;
            aob_pkg::t_quo quo_i;
            if (g == 0) begin : g_first
                assign quo_i = '0;
            end else begin : g_rest
                assign quo_i = r_quo[g][c];
            end
            aob_div_stage #(
                .HI(aob_pkg::Q_W - 1 - g * aob_pkg::DIV_STEPS)
            ) u_div (
                .i_rem (r_rem[g][c]),
                .i_quo (quo_i),
                .i_den (r_den[g]),
                .o_rem (rem_n),
                .o_quo (quo_n)
            );
            always_ff @(posedge i_clk) begin
                if (en[g+2]) begin
                    r_rem[g+1][c] <= rem_n;
                    r_quo[g+1][c] <= quo_n;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[g+2]) begin
                r_den[g+1] <= r_den[g];
                r_al[g+1]  <= r_al[g];
                r_byp[g+1] <= r_byp[g];
                r_bpx[g+1] <= r_bpx[g];
            end
        end
    end

    // stage 5: clamp, assemble, apply bypass
    aob_pkg::t_px n_px;
    aob_pkg::t_px r_px;
    aob_pkg::t_quo qf;

    always_comb begin
        n_px = {r_al[aob_pkg::DIV_STGS], 24'd0};
        for (int c = 0; c < aob_pkg::N_COLOR; c++) begin
            qf = r_quo[aob_pkg::DIV_STGS][c];
            n_px[c*CW +: CW] = qf[aob_pkg::Q_W-1] ? aob_pkg::CH_MAX : qf[CW-1:0];
        end
        if (r_byp[aob_pkg::DIV_STGS]) begin
            n_px = r_bpx[aob_pkg::DIV_STGS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_px <= n_px;
        end
    end

    assign o_out_pixel = r_px;

endmodule

`default_nettype wire
